[sv/gkl_pkg.sv]
// package for the symmetric kl divergence block: widths, codes and the
// command/status structs shared by the controller and the datapath
// no dependencies
package gkl_pkg;

   // fixed field widths
   localparam int DATA_W        = 32;
   localparam int VSUM_W        = DATA_W + 1;
   localparam int PROD_W        = DATA_W + VSUM_W;
   localparam int SQ_W          = 2 * DATA_W;
   localparam int SUM_W         = 48;
   localparam int STAT_W        = 2;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_ZERO_VAR = 2'd1;
   localparam logic [STAT_W-1:0] ST_SAT      = 2'd2;

   // multiplier passes, issued in this order
   localparam int MUL_OP_W = 3;
   typedef logic [MUL_OP_W-1:0] mul_op_type;
   localparam mul_op_type OP_DM2 = 3'd0;   // (ma-mb)^2
   localparam mul_op_type OP_DV2 = 3'd1;   // (va-vb)^2
   localparam mul_op_type OP_DEN = 3'd2;   // va*vb
   localparam mul_op_type OP_P0  = 3'd3;   // low half of (ma-mb)^2 times (va+vb)
   localparam mul_op_type OP_P1  = 3'd4;   // high half of (ma-mb)^2 times (va+vb)
   localparam int MUL_OPS = 5;

   // divider steps, one quotient bit each
   localparam int DIV_STEPS = SUM_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic       load;
      logic       prep;
      logic       mul_en;
      mul_op_type mul_op;
      logic       wr_en;
      mul_op_type wr_op;
      logic       sat_chk;
      logic       div_step;
      logic       acc;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic zero_var;
      logic last;
   } stat_type;

endpackage

[sv/gkl_datapath.sv]
// datapath: operand registers, shared multiplier, numerator build,
// bit-serial divider, running sum and output register
// depends on gkl_pkg
module gkl_datapath
   import gkl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [DATA_W-1:0]   mean_a,
   input  logic [DATA_W-1:0]   var_a,
   input  logic [DATA_W-1:0]   mean_b,
   input  logic [DATA_W-1:0]   var_b,
   input  logic                last_dim,
   output logic [SUM_W-1:0]    distance,
   output logic [STAT_W-1:0]   status
);

   // numerator holds (va-vb)^2 << FRAC_BITS plus (ma-mb)^2*(va+vb)
   localparam int NUM_A_W = SQ_W + FRAC_BITS;
   localparam int NUM_B_W = SQ_W + VSUM_W;
   localparam int NUM_W   = ((NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W) + 1;
   localparam int CMP_W   = SQ_W + SUM_W;

   // captured transaction
   logic [DATA_W-1:0] ma_ff, va_ff, mb_ff, vb_ff;
   logic              last_ff;

   // prepared operands
   logic [DATA_W-1:0] dv_ff, dv_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic [VSUM_W-1:0] vs_ff, vs_in;
   logic [VSUM_W-1:0] dm_diff, dm_neg;

   // multiplier
   logic [DATA_W-1:0] mul_a;
   logic [VSUM_W-1:0] mul_b;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // products and numerator
   logic [SQ_W-1:0]  dm2_ff, den_ff;
   logic [NUM_W-1:0] num_ff;

   // divider
   logic               sat_ff;
   logic [SQ_W-1:0]    rem_ff;
   logic [SUM_W-1:0]   q_ff;
   logic [SQ_W:0]      trial, trial_diff;
   logic               trial_ge;

   // accumulation
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [STAT_W-1:0]  stk_ff, stk_in;
   logic [SUM_W-1:0]   term, sum_next;
   logic [SUM_W:0]     sum_wide;
   logic [STAT_W-1:0]  stk_next;
   logic [SUM_W-1:0]   dist_ff;
   logic [STAT_W-1:0]  rstat_ff;

   assign stat.zero_var = (va_ff == '0) || (vb_ff == '0);
   assign stat.last     = last_ff;

   // capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ma_ff   <= mean_a;
         va_ff   <= var_a;
         mb_ff   <= mean_b;
         vb_ff   <= var_b;
         last_ff <= last_dim;
      end
   end

   // differences and variance sum
   always_comb begin
      dv_in   = (va_ff > vb_ff) ? (va_ff - vb_ff) : (vb_ff - va_ff);
      dm_diff = {ma_ff[DATA_W-1], ma_ff} - {mb_ff[DATA_W-1], mb_ff};
      dm_neg  = '0 - dm_diff;
      dmag_in = dm_diff[VSUM_W-1] ? dm_neg[DATA_W-1:0] : dm_diff[DATA_W-1:0];
      vs_in   = {1'b0, va_ff} + {1'b0, vb_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         dv_ff   <= dv_in;
         dmag_ff <= dmag_in;
         vs_ff   <= vs_in;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         OP_DM2: begin
            mul_a = dmag_ff;
            mul_b = {1'b0, dmag_ff};
         end
         OP_DV2: begin
            mul_a = dv_ff;
            mul_b = {1'b0, dv_ff};
         end
         OP_DEN: begin
            mul_a = va_ff;
            mul_b = {1'b0, vb_ff};
         end
         OP_P0: begin
            mul_a = dm2_ff[DATA_W-1:0];
            mul_b = vs_ff;
         end
         OP_P1: begin
            mul_a = dm2_ff[SQ_W-1:DATA_W];
            mul_b = vs_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // product write-back and numerator build
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         case (cmd.wr_op)
            OP_DM2: dm2_ff <= prod_ff[SQ_W-1:0];
            OP_DV2: num_ff <= NUM_W'(prod_ff[SQ_W-1:0]) << FRAC_BITS;
            OP_DEN: den_ff <= prod_ff[SQ_W-1:0];
            OP_P0:  num_ff <= num_ff + NUM_W'(prod_ff);
            OP_P1:  num_ff <= num_ff + (NUM_W'(prod_ff) << DATA_W);
            default: ;
         endcase
      end
   end

   // divider: quotient overflow check, then one restoring step a cycle
   always_comb begin
      trial      = {rem_ff, q_ff[SUM_W-1]};
      trial_ge   = trial >= {1'b0, den_ff};
      trial_diff = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.sat_chk) begin
         sat_ff <= CMP_W'(num_ff) >= {den_ff, {SUM_W{1'b0}}};
         rem_ff <= SQ_W'(num_ff >> SUM_W);
         q_ff   <= num_ff[SUM_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_diff[SQ_W-1:0] : trial[SQ_W-1:0];
         q_ff   <= {q_ff[SUM_W-2:0], trial_ge};
      end
   end

   // running sum with saturation and sticky status
   always_comb begin
      term     = sat_ff ? SUM_MAX : q_ff;
      sum_wide = {1'b0, sum_ff} + {1'b0, term};
      sum_next = sum_ff;
      stk_next = stk_ff;
      if (cmd.acc) begin
         if (stat.zero_var) begin
            stk_next = ST_ZERO_VAR;
         end else if (sum_wide[SUM_W]) begin
            sum_next = SUM_MAX;
            if (stk_ff == ST_OK) begin
               stk_next = ST_SAT;
            end
         end else begin
            sum_next = sum_wide[SUM_W-1:0];
         end
      end
      sum_in = cmd.emit ? '0 : sum_next;
      stk_in = cmd.emit ? ST_OK : stk_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         stk_ff <= ST_OK;
      end else begin
         sum_ff <= sum_in;
         stk_ff <= stk_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         dist_ff  <= sum_next;
         rstat_ff <= stk_next;
      end
   end

   assign distance = dist_ff;
   assign status   = rstat_ff;

endmodule

[sv/gkl_ctrl.sv]
// controller: sequences capture, multiplier passes, divider steps and
// accumulation, and owns both handshakes
// depends on gkl_pkg
module gkl_ctrl
   import gkl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SAT  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_ACC  = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cnt_in = '0;
            if (stat.zero_var) begin
               state_in = S_ACC;
            end else begin
               cmd.prep = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // issue pass n while writing back pass n-1
            cmd.mul_en = (cnt_ff < CNT_W'(MUL_OPS));
            cmd.mul_op = mul_op_type'(cnt_ff);
            cmd.wr_en  = (cnt_ff != '0);
            cmd.wr_op  = mul_op_type'(cnt_ff - 1'b1);
            if (cnt_ff == CNT_W'(MUL_OPS)) begin
               cnt_in   = '0;
               state_in = S_SAT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SAT: begin
            cmd.sat_chk = 1'b1;
            cnt_in      = '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (!stat.last) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath phases never overlap
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.sat_chk, cmd.div_step, cmd.acc}))
      else $error("datapath phases overlap");

   // every multiplier pass is written back in the following cycle
   a_mul_writeback: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |=> cmd.wr_en)
      else $error("multiplier product not written back");

   // the overflow check is followed directly by the divider
   a_sat_then_div: assert property (@(posedge clock) disable iff (reset)
      cmd.sat_chk |=> cmd.div_step)
      else $error("divider did not start after overflow check");

   // a loaded result is presented on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("result not presented after load");

   // divider counter stays in range
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider step count out of range");

endmodule

[sv/gaussian_kl_divergence_top.sv]
// symmetric kl divergence of two diagonal gaussians, one dimension per transaction
// a zero-variance dimension skips the multiplier and divider and goes straight to accumulation
// a new transaction is accepted only once the previous one is through; its time is set by the 48-step
// bit-serial divider plus five passes of the shared multiplier
// reset: synchronous, active high; clears the running sum, sticky status and result valid
// depends on gkl_pkg, gkl_ctrl and gkl_datapath
module gaussian_kl_divergence_top
   import gkl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [4*DATA_W-1:0]   req_tdata,   // mean_a, var_a, mean_b, var_b
   input  logic                  req_tlast,   // last_dim
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SUM_W-1:0]      rsp_tdata,   // distance
   output logic [STAT_W-1:0]     rsp_tuser    // status
);

   cmd_type  cmd;
   stat_type stat;

   gkl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gkl_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .mean_a   (req_tdata[DATA_W-1:0]),
      .var_a    (req_tdata[2*DATA_W-1:DATA_W]),
      .mean_b   (req_tdata[3*DATA_W-1:2*DATA_W]),
      .var_b    (req_tdata[4*DATA_W-1:3*DATA_W]),
      .last_dim (req_tlast),
      .distance (rsp_tdata),
      .status   (rsp_tuser)
   );

endmodule
